// ===== sv/lkvt_pkg.sv =====
// Shared types, codes and default sizes for the linear key/value table.
package lkvt_pkg;

    localparam int CAPACITY_DEF    = 256;
    localparam int KEY_WIDTH_DEF   = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int OP_W    = 3;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int IDX_W   = 8;
    localparam int CNT_W   = 9;
    localparam int MAX_W   = 9;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [MAX_W-1:0]  MAX_ENTRIES_RST  = 9'd256;
    localparam logic [APB_AW-1:0] ADDR_MAX_ENTRIES = 3'd0;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT           = 3'd0,
        OP_UPDATE           = 3'd1,
        OP_INSERT_OR_UPDATE = 3'd2,
        OP_ERASE            = 3'd3,
        OP_LOOKUP           = 3'd4,
        OP_READ_AT_INDEX    = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_EMOVE,
        S_RDIDX,
        S_RDDATA,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] index;
    } t_in;

    typedef struct packed {
        logic             ok;
        logic [KEY_W-1:0] out_key;
        logic [VAL_W-1:0] out_value;
        logic [CNT_W-1:0] count;
        logic             is_empty;
    } t_out;

endpackage

// ===== sv/lkvt_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module lkvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/lkvt_cfg.sv =====
// APB register block holding the entry limit.
module lkvt_cfg
    import lkvt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [MAX_W-1:0]  o_max_entries
);

    logic [MAX_W-1:0] r_max_entries;
    logic             wr_hit;

    assign wr_hit = psel && penable && pwrite && (paddr == ADDR_MAX_ENTRIES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= MAX_ENTRIES_RST;
        end else if (wr_hit) begin
            r_max_entries <= pwdata[MAX_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_MAX_ENTRIES) begin
            prdata = APB_DW'(r_max_entries);
        end
    end

    assign pready        = 1'b1;
    assign o_max_entries = r_max_entries;

endmodule

// ===== sv/lkvt_ctrl.sv =====
// Sequencer, key comparator, entry storage and result register of the table.
module lkvt_ctrl
    import lkvt_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [MAX_W-1:0] i_max_entries,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in              i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out             o_out_data
);

    localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int LW  = (CW > MAX_W) ? CW : MAX_W;
    localparam int IXW = (CW > IDX_W) ? CW : IDX_W;

    t_state                 r_state, n_state;
    t_op                    r_op, n_op;
    logic [KEY_WIDTH-1:0]   r_key, n_key;
    logic [VALUE_WIDTH-1:0] r_val, n_val;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_ptr, n_ptr;
    logic                   r_rd_vld, n_rd_vld;
    logic [AW-1:0]          r_rd_idx, n_rd_idx;
    logic                   r_found, n_found;
    logic [AW-1:0]          r_pos, n_pos;
    logic [VALUE_WIDTH-1:0] r_hit_val, n_hit_val;
    logic                   r_res_ok, n_res_ok;
    logic [KEY_WIDTH-1:0]   r_res_key, n_res_key;
    logic [VALUE_WIDTH-1:0] r_res_val, n_res_val;
    logic                   r_out_valid, n_out_valid;
    t_out                   r_out, n_out;

    logic                   accept;
    logic                   out_free;
    logic                   issue;
    logic                   hit;
    logic                   miss_done;
    logic                   idx_ok;
    logic                   room;
    logic [LW-1:0]          limit;

    logic                   key_we, val_we, ram_re;
    logic [AW-1:0]          waddr, raddr;
    logic [KEY_WIDTH-1:0]   key_wdata, key_rdata;
    logic [VALUE_WIDTH-1:0] val_wdata, val_rdata;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign issue     = r_ptr < r_count;
    assign hit       = r_rd_vld && (key_rdata == r_key);
    assign miss_done = !r_rd_vld && !issue;
    assign idx_ok    = IXW'(r_idx) < IXW'(r_count);
    assign limit     = (LW'(i_max_entries) > LW'(CAPACITY)) ? LW'(CAPACITY)
                                                            : LW'(i_max_entries);
    assign room      = LW'(r_count) < limit;

    lkvt_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (waddr),
        .i_wdata (key_wdata),
        .i_re    (ram_re),
        .i_raddr (raddr),
        .o_rdata (key_rdata)
    );

    lkvt_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (waddr),
        .i_wdata (val_wdata),
        .i_re    (ram_re),
        .i_raddr (raddr),
        .o_rdata (val_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in_data.op) inside
                        OP_READ_AT_INDEX: n_state = S_RDIDX;
                        OP_INSERT, OP_UPDATE, OP_INSERT_OR_UPDATE,
                        OP_ERASE, OP_LOOKUP: n_state = S_SCAN;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (hit || miss_done) begin
                    n_state = S_ACT;
                end
            end
            S_ACT: begin
                n_state = (r_op == OP_ERASE && r_found) ? S_EMOVE : S_DONE;
            end
            S_EMOVE:  n_state = S_DONE;
            S_RDIDX:  n_state = idx_ok ? S_RDDATA : S_DONE;
            S_RDDATA: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_op      = r_op;
        n_key     = r_key;
        n_val     = r_val;
        n_idx     = r_idx;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_rd_vld  = 1'b0;
        n_rd_idx  = r_rd_idx;
        n_found   = r_found;
        n_pos     = r_pos;
        n_hit_val = r_hit_val;
        n_res_ok  = r_res_ok;
        n_res_key = r_res_key;
        n_res_val = r_res_val;
        key_we    = 1'b0;
        val_we    = 1'b0;
        ram_re    = 1'b0;
        waddr     = r_pos;
        raddr     = AW'(r_ptr);
        key_wdata = r_key;
        val_wdata = r_val;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op      = i_in_data.op;
                    n_key     = KEY_WIDTH'(i_in_data.key);
                    n_val     = VALUE_WIDTH'(i_in_data.value);
                    n_idx     = i_in_data.index;
                    n_ptr     = '0;
                    n_found   = 1'b0;
                    n_res_ok  = 1'b0;
                    n_res_key = '0;
                    n_res_val = '0;
                end
            end
            S_SCAN: begin
                ram_re   = issue;
                n_rd_vld = issue;
                n_rd_idx = AW'(r_ptr);
                if (issue) begin
                    n_ptr = r_ptr + 1'b1;
                end
                if (hit) begin
                    n_found   = 1'b1;
                    n_pos     = r_rd_idx;
                    n_hit_val = val_rdata;
                end
            end
            S_ACT: begin
                ram_re = 1'b1;
                raddr  = AW'(r_count - 1'b1);
                case (r_op)
                    OP_INSERT: begin
                        if (!r_found && room) begin
                            key_we   = 1'b1;
                            val_we   = 1'b1;
                            waddr    = AW'(r_count);
                            n_count  = r_count + 1'b1;
                            n_res_ok = 1'b1;
                        end
                    end
                    OP_UPDATE: begin
                        if (r_found) begin
                            val_we   = 1'b1;
                            n_res_ok = 1'b1;
                        end
                    end
                    OP_INSERT_OR_UPDATE: begin
                        if (r_found) begin
                            val_we   = 1'b1;
                            n_res_ok = 1'b1;
                        end else if (room) begin
                            key_we   = 1'b1;
                            val_we   = 1'b1;
                            waddr    = AW'(r_count);
                            n_count  = r_count + 1'b1;
                            n_res_ok = 1'b1;
                        end
                    end
                    OP_LOOKUP: begin
                        if (r_found) begin
                            n_res_ok  = 1'b1;
                            n_res_val = r_hit_val;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_EMOVE: begin
                key_we    = 1'b1;
                val_we    = 1'b1;
                key_wdata = key_rdata;
                val_wdata = val_rdata;
                n_count   = r_count - 1'b1;
                n_res_ok  = 1'b1;
            end
            S_RDIDX: begin
                ram_re = idx_ok;
                raddr  = AW'(r_idx);
            end
            S_RDDATA: begin
                n_res_ok  = 1'b1;
                n_res_key = key_rdata;
                n_res_val = val_rdata;
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        if (r_state == S_DONE && out_free) begin
            n_out_valid        = 1'b1;
            n_out.ok           = r_res_ok;
            n_out.out_key      = KEY_W'(r_res_key);
            n_out.out_value    = VAL_W'(r_res_val);
            n_out.count        = CNT_W'(r_count);
            n_out.is_empty     = (r_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_key     <= n_key;
        r_val     <= n_val;
        r_idx     <= n_idx;
        r_ptr     <= n_ptr;
        r_rd_idx  <= n_rd_idx;
        r_found   <= n_found;
        r_pos     <= n_pos;
        r_hit_val <= n_hit_val;
        r_res_ok  <= n_res_ok;
        r_res_key <= n_res_key;
        r_res_val <= n_res_val;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== sv/linear_key_value_table.sv =====
// Top level of the linear key/value table.
// The table holds up to CAPACITY unique key/value pairs in two RAMs and answers one
// request at a time, one result beat per request beat. Keyed operations (insert,
// update, insert-or-update, erase, lookup) scan the stored entries from index 0 with
// one key comparison per cycle. A request whose key is absent scans every stored
// entry and then passes through the action and done states; a key that is found
// ends the scan early, and erase adds a move step that writes the last entry into
// the hole. Read-at-index needs no scan: it reads the entry at the index, or goes
// to the done state when the index is out of range; an unused op code goes straight
// to the done state. A result that cannot enter the output register waits in the
// done state. The scan rate is set by the single read port of the key RAM. The input
// is stalled from acceptance until the result is loaded into the output register; a
// result that waits there does not hold off the next request. The max_entries
// register at byte address 0 limits inserts; values above CAPACITY act as CAPACITY.
module linear_key_value_table
    import lkvt_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in               i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out              o_out_data
);

    logic [MAX_W-1:0] max_entries;

    lkvt_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_max_entries (max_entries)
    );

    lkvt_ctrl #(
        .CAPACITY    (CAPACITY),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_max_entries (max_entries),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

endmodule

// ===== sv/lkvt_chk.sv =====
// Port-level checker for the linear key/value table and its bind.
module lkvt_chk
    import lkvt_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("Result beat dropped while stalled.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("Request accepted without the input going busy.");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.is_empty == (o_out_data.count == '0)))
        else $error("Empty flag disagrees with the count.");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.ok |->
            (o_out_data.out_key == '0) && (o_out_data.out_value == '0))
        else $error("Failed result carries a nonzero key or value.");

endmodule

bind linear_key_value_table lkvt_chk u_lkvt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the linear key/value table: directed table, then random phases.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lkvt_pkg::*;

    localparam int CAP          = CAPACITY_DEF;
    localparam int HANG_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = CAP + 16;
    localparam int LONG_HOLD    = 600;
    localparam int POOL_SIZE    = 32;

    typedef enum {MIX_ALL, MIX_FILL, MIX_SHRINK} t_mix;

    typedef struct {
        bit               is_cfg;
        logic [MAX_W-1:0] lim;
        t_in              req;
        bit               typed;
        t_out             res;
    } t_row;

    typedef struct {
        logic [MAX_W-1:0] lim;
        int               n;
        t_mix             mix;
    } t_phase;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    t_in               i_in_data = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out              o_out_data;

    logic [KEY_W-1:0]  shadow_keys [CAP];
    logic [VAL_W-1:0]  shadow_vals [CAP];
    int                shadow_count = 0;
    logic [MAX_W-1:0]  shadow_limit = MAX_ENTRIES_RST;
    logic [KEY_W-1:0]  key_pool [POOL_SIZE];
    t_out              answers_due [$];
    int                err_cnt = 0;
    int                beats_in = 0;
    int                beats_out = 0;
    int                cfg_writes = 0;
    bit                quiet = 1'b0;
    bit                hold_req = 1'b0;

    linear_key_value_table i_dut (
        .i_clk,
        .i_rst_n,
        .psel,
        .penable,
        .pwrite,
        .paddr,
        .pwdata,
        .prdata,
        .pready,
        .i_in_valid,
        .o_in_stall,
        .i_in_data,
        .o_out_valid,
        .i_out_stall,
        .o_out_data
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int find_slot(logic [KEY_W-1:0] k);
        for (int i = 0; i < shadow_count; i++) begin
            if (shadow_keys[i] == k) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic bit table_append(logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        int lim;
        lim = (shadow_limit > CAP) ? CAP : int'(shadow_limit);
        if (find_slot(k) >= 0 || shadow_count >= lim) begin
            return 1'b0;
        end
        shadow_keys[shadow_count] = k;
        shadow_vals[shadow_count] = v;
        shadow_count++;
        return 1'b1;
    endfunction

    function automatic t_out table_apply(t_in req);
        t_out res;
        int   pos;
        res = '0;
        pos = find_slot(req.key);
        case (req.op)
            OP_INSERT: begin
                res.ok = table_append(req.key, req.value);
            end
            OP_UPDATE: begin
                if (pos >= 0) begin
                    shadow_vals[pos] = req.value;
                    res.ok = 1'b1;
                end
            end
            OP_INSERT_OR_UPDATE: begin
                if (pos >= 0) begin
                    shadow_vals[pos] = req.value;
                    res.ok = 1'b1;
                end else begin
                    res.ok = table_append(req.key, req.value);
                end
            end
            OP_ERASE: begin
                if (pos >= 0) begin
                    shadow_keys[pos] = shadow_keys[shadow_count-1];
                    shadow_vals[pos] = shadow_vals[shadow_count-1];
                    shadow_count--;
                    res.ok = 1'b1;
                end
            end
            OP_LOOKUP: begin
                if (pos >= 0) begin
                    res.ok = 1'b1;
                    res.out_value = shadow_vals[pos];
                end
            end
            OP_READ_AT_INDEX: begin
                if (int'(req.index) < shadow_count) begin
                    res.ok = 1'b1;
                    res.out_key = shadow_keys[req.index];
                    res.out_value = shadow_vals[req.index];
                end
            end
            default: begin
            end
        endcase
        res.count = shadow_count[CNT_W-1:0];
        res.is_empty = (shadow_count == 0);
        return res;
    endfunction

    function automatic t_row req_row(t_op op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                                     logic [IDX_W-1:0] idx);
        t_row row;
        row = '{default: '0};
        row.req = '{op: op, key: k, value: v, index: idx};
        return row;
    endfunction

    function automatic t_row typed_row(t_op op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                                       logic [IDX_W-1:0] idx, bit ok, logic [KEY_W-1:0] ok_key,
                                       logic [VAL_W-1:0] ok_val, int cnt);
        t_row row;
        row = req_row(op, k, v, idx);
        row.typed = 1'b1;
        row.res = '{ok: ok, out_key: ok_key, out_value: ok_val,
                    count: CNT_W'(cnt), is_empty: (cnt == 0)};
        return row;
    endfunction

    function automatic t_row cfg_row(logic [MAX_W-1:0] lim);
        t_row row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.lim = lim;
        return row;
    endfunction

    function automatic t_in random_request(t_mix mix);
        t_in req;
        int  r;
        int  pick;
        int  top;
        r = $urandom_range(0, 99);
        pick = $urandom_range(0, 99);
        if (mix == MIX_FILL && r < 85) begin
            req.op = (r < 60) ? OP_INSERT : OP_INSERT_OR_UPDATE;
        end else if (mix == MIX_SHRINK && r < 55) begin
            req.op = OP_ERASE;
        end else if (pick < 20) begin
            req.op = OP_INSERT;
        end else if (pick < 35) begin
            req.op = OP_UPDATE;
        end else if (pick < 50) begin
            req.op = OP_INSERT_OR_UPDATE;
        end else if (pick < 63) begin
            req.op = OP_ERASE;
        end else if (pick < 80) begin
            req.op = OP_LOOKUP;
        end else if (pick < 96) begin
            req.op = OP_READ_AT_INDEX;
        end else begin
            req.op = t_op'(OP_W'($urandom_range(6, 7)));
        end
        pick = $urandom_range(0, 99);
        if (mix == MIX_FILL && pick < 90
                && (req.op == OP_INSERT || req.op == OP_INSERT_OR_UPDATE)) begin
            req.key = $urandom;
        end else if (pick < 45 && shadow_count > 0) begin
            req.key = shadow_keys[$urandom_range(0, shadow_count - 1)];
        end else if (pick < 80) begin
            req.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
            req.key = $urandom;
        end
        req.value = $urandom;
        top = (shadow_count + 1 > 255) ? 255 : shadow_count + 1;
        if ($urandom_range(0, 4) == 0) begin
            req.index = IDX_W'($urandom_range(0, 255));
        end else begin
            req.index = IDX_W'($urandom_range(0, top));
        end
        return req;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            err_cnt++;
        end
    endfunction

    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (answers_due.size() != 0);
    endtask

    task automatic cfg_write(logic [MAX_W-1:0] lim);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_MAX_ENTRIES;
        pwdata <= APB_DW'(lim);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        shadow_limit = lim;
        cfg_writes++;
    endtask

    task automatic offer(t_in req, bit typed, t_out res);
        int   gap;
        t_out pred;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        beats_in++;
        pred = table_apply(req);
        answers_due.push_back(typed ? res : pred);
    endtask

    initial begin
        t_row   dir_rows [$];
        t_phase phases [$];
        dir_rows = '{
            typed_row(OP_LOOKUP, 32'h0, 32'h0, 8'h00, 1'b0, 32'h0, 32'h0, 0),
            typed_row(OP_ERASE, 32'hFFFF_FFFF, 32'h0, 8'h00, 1'b0, 32'h0, 32'h0, 0),
            typed_row(OP_READ_AT_INDEX, 32'h0, 32'h0, 8'h00, 1'b0, 32'h0, 32'h0, 0),
            typed_row(OP_UPDATE, 32'h5, 32'h1, 8'h00, 1'b0, 32'h0, 32'h0, 0),
            typed_row(t_op'(3'd6), 32'h0, 32'h0, 8'h00, 1'b0, 32'h0, 32'h0, 0),
            typed_row(OP_INSERT, 32'h0, 32'hFFFF_FFFF, 8'h00, 1'b1, 32'h0, 32'h0, 1),
            typed_row(OP_INSERT, 32'hFFFF_FFFF, 32'h0, 8'hFF, 1'b1, 32'h0, 32'h0, 2),
            typed_row(OP_INSERT, 32'h0, 32'h1, 8'h00, 1'b0, 32'h0, 32'h0, 2),
            typed_row(OP_LOOKUP, 32'h0, 32'h0, 8'h00, 1'b1, 32'h0, 32'hFFFF_FFFF, 2),
            typed_row(OP_READ_AT_INDEX, 32'h0, 32'h0, 8'h01, 1'b1, 32'hFFFF_FFFF, 32'h0, 2),
            typed_row(OP_READ_AT_INDEX, 32'h0, 32'h0, 8'hFF, 1'b0, 32'h0, 32'h0, 2),
            req_row(OP_UPDATE, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 8'h00),
            req_row(OP_INSERT_OR_UPDATE, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 8'h00),
            req_row(OP_INSERT_OR_UPDATE, 32'h8000_0000, 32'h1234_5678, 8'h00),
            typed_row(t_op'(3'd7), 32'h8000_0000, 32'h0, 8'h00, 1'b0, 32'h0, 32'h0, 3),
            req_row(OP_ERASE, 32'h0, 32'h0, 8'h00),
            req_row(OP_READ_AT_INDEX, 32'h0, 32'h0, 8'h00),
            typed_row(OP_LOOKUP, 32'h0, 32'h0, 8'h00, 1'b0, 32'h0, 32'h0, 2),
            req_row(OP_ERASE, 32'h8000_0000, 32'h0, 8'h00),
            typed_row(OP_ERASE, 32'hFFFF_FFFF, 32'h0, 8'h00, 1'b1, 32'h0, 32'h0, 0),
            cfg_row(9'd0),
            typed_row(OP_INSERT, 32'h1, 32'h2, 8'h00, 1'b0, 32'h0, 32'h0, 0),
            cfg_row(9'd1),
            typed_row(OP_INSERT_OR_UPDATE, 32'h1, 32'h2, 8'h00, 1'b1, 32'h0, 32'h0, 1),
            typed_row(OP_INSERT, 32'h2, 32'h3, 8'h00, 1'b0, 32'h0, 32'h0, 1),
            cfg_row(9'd511),
            typed_row(OP_INSERT, 32'h2, 32'h3, 8'h00, 1'b1, 32'h0, 32'h0, 2)
        };
        phases = '{
            '{9'd511, 120, MIX_ALL},
            '{9'd8, 150, MIX_ALL},
            '{9'd256, 360, MIX_FILL},
            '{9'd200, 150, MIX_SHRINK},
            '{9'd0, 40, MIX_ALL},
            '{9'd1, 250, MIX_SHRINK},
            '{9'd16, 150, MIX_ALL},
            '{9'd3, 100, MIX_ALL},
            '{9'd511, 100, MIX_ALL}
        };
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                settle();
                cfg_write(dir_rows[i].lim);
            end else begin
                offer(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
            end
        end
        foreach (phases[p]) begin
            settle();
            if (p == phases.size() - 1) begin
                quiet = 1'b1;
            end
            cfg_write(phases[p].lim);
            for (int j = 0; j < POOL_SIZE; j++) begin
                key_pool[j] = (j == 0) ? '0 : (j == 1) ? '1 : KEY_W'($urandom);
            end
            for (int n = 0; n < phases[p].n; n++) begin
                if (p == 3 && n == 40) begin
                    hold_req = 1'b1;
                end
                if (p == 6 && n == 60) begin
                    settle();
                end
                offer(random_request(phases[p].mix), 1'b0, '0);
            end
        end
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        int   left;
        bit   hold;
        t_out want;
        left = 0;
        hold = 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                beats_out++;
                if (answers_due.size() == 0) begin
                    $error("result beat arrived with no request pending");
                    err_cnt++;
                end else begin
                    want = answers_due.pop_front();
                    check_field("ok", 32'(want.ok), 32'(o_out_data.ok));
                    check_field("out_key", want.out_key, o_out_data.out_key);
                    check_field("out_value", want.out_value, o_out_data.out_value);
                    check_field("count", 32'(want.count), 32'(o_out_data.count));
                    check_field("is_empty", 32'(want.is_empty), 32'(o_out_data.is_empty));
                end
            end
            if (left == 0) begin
                if (hold_req) begin
                    hold_req = 1'b0;
                    hold = 1'b1;
                    left = LONG_HOLD;
                end else if (!quiet && $urandom_range(0, 2) == 0) begin
                    hold = 1'b1;
                    left = $urandom_range(1, 12);
                end else begin
                    hold = 1'b0;
                    left = $urandom_range(1, 24);
                end
            end
            left--;
            i_out_stall <= hold;
        end
    end

    initial begin
        int idle_cycles;
        int seen;
        int now_total;
        idle_cycles = 0;
        seen = 0;
        while (idle_cycles < HANG_LIMIT) begin
            @(posedge i_clk);
            now_total = beats_in + beats_out + cfg_writes;
            if (now_total != seen) begin
                seen = now_total;
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/lkvt_pkg.sv
sv/lkvt_ram.sv
sv/lkvt_cfg.sv
sv/lkvt_ctrl.sv
sv/linear_key_value_table.sv
sv/lkvt_chk.sv
verif/tb_top.sv
